// ----- hdl/ttc_pkg.sv -----
// Shared constants, command codes and the month table for the timestamp-to-calendar block.
// No dependencies; every other file of the block imports this package.
package ttc_pkg;

   // Input formats selected by the func field.
   localparam logic [1:0] FMT_STRUCT  = 2'd0;
   localparam logic [1:0] FMT_IEC     = 2'd1;
   localparam logic [1:0] FMT_MICRO   = 2'd2;
   localparam logic [1:0] FMT_SECONDS = 2'd3;

   // Calendar constants.
   localparam logic [31:0] EPOCH_SHIFT     = 32'd315532800;
   localparam int unsigned HOURS_PER_QUAD  = 1461 * 24;
   localparam int unsigned HOURS_LEAP_YEAR = 366 * 24;
   localparam int unsigned HOURS_PLAIN     = 365 * 24;
   localparam logic [11:0] BASE_YEAR       = 12'd1980;
   localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

   // Reciprocal multipliers: q = (x * RECIP) >> SHIFT is exact for the ranges used here.
   localparam int unsigned SHIFT_60    = 37;
   localparam logic [63:0] RECIP_60    = ((64'd1 << SHIFT_60) + 64'd59) / 64'd60;
   localparam int unsigned SHIFT_US    = 38;
   localparam logic [63:0] RECIP_US    = ((64'd1 << SHIFT_US) + 64'd999) / 64'd1000;
   localparam int unsigned SHIFT_MS    = 26;
   localparam logic [63:0] RECIP_MS    = ((64'd1 << SHIFT_MS) + 64'd999) / 64'd1000;
   localparam int unsigned SHIFT_QUAD  = 40;
   localparam logic [63:0] RECIP_QUAD  =
      ((64'd1 << SHIFT_QUAD) + 64'(HOURS_PER_QUAD) - 64'd1) / 64'(HOURS_PER_QUAD);
   localparam int unsigned SHIFT_DAY   = 20;
   localparam logic [63:0] RECIP_DAY   = ((64'd1 << SHIFT_DAY) + 64'd23) / 64'd24;

   // Commands from the controller to the datapath.
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_MUL_SEC,
      CMD_DIV_SEC,
      CMD_MUL_MIN,
      CMD_DIV_MIN,
      CMD_MUL_QUAD,
      CMD_DIV_QUAD,
      CMD_YEAR,
      CMD_MUL_DAY,
      CMD_DIV_DAY,
      CMD_RESULT
   } ttc_cmd_type;

   // Days of a common year that come before the given month (0 is January).
   function automatic logic [8:0] cum_days(input logic [3:0] month_idx);
      logic [8:0] days;
      unique case (month_idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ----- hdl/ttc_ctrl.sv -----
// Sequencing controller for the timestamp-to-calendar block.
// Depends on ttc_pkg for the datapath command codes.
module ttc_ctrl
   import ttc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ttc_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SEC,
      ST_DIV_SEC,
      ST_MUL_MIN,
      ST_DIV_MIN,
      ST_MUL_QUAD,
      ST_DIV_QUAD,
      ST_YEAR,
      ST_MUL_DAY,
      ST_DIV_DAY,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   // The result register can be written when it is empty or is being taken this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode for the datapath.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:     cmd = req_valid ? CMD_LOAD : CMD_IDLE;
         ST_MUL_SEC:  cmd = CMD_MUL_SEC;
         ST_DIV_SEC:  cmd = CMD_DIV_SEC;
         ST_MUL_MIN:  cmd = CMD_MUL_MIN;
         ST_DIV_MIN:  cmd = CMD_DIV_MIN;
         ST_MUL_QUAD: cmd = CMD_MUL_QUAD;
         ST_DIV_QUAD: cmd = CMD_DIV_QUAD;
         ST_YEAR:     cmd = CMD_YEAR;
         ST_MUL_DAY:  cmd = CMD_MUL_DAY;
         ST_DIV_DAY:  cmd = CMD_DIV_DAY;
         ST_RESULT:   cmd = slot_free ? CMD_RESULT : CMD_IDLE;
         default:     cmd = CMD_IDLE;
      endcase
   end

   // State register and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result fills the register; otherwise a taken result empties it.
         if (state_ff == ST_RESULT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MUL_SEC;
               end
            end
            ST_MUL_SEC:  state_ff <= ST_DIV_SEC;
            ST_DIV_SEC:  state_ff <= ST_MUL_MIN;
            ST_MUL_MIN:  state_ff <= ST_DIV_MIN;
            ST_DIV_MIN:  state_ff <= ST_MUL_QUAD;
            ST_MUL_QUAD: state_ff <= ST_DIV_QUAD;
            ST_DIV_QUAD: state_ff <= ST_YEAR;
            ST_YEAR:     state_ff <= ST_MUL_DAY;
            ST_MUL_DAY:  state_ff <= ST_DIV_DAY;
            ST_DIV_DAY:  state_ff <= ST_RESULT;
            ST_RESULT: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- hdl/ttc_dpath.sv -----
// Arithmetic datapath: format decode, constant divisions by reciprocal multiply, calendar split.
// Depends on ttc_pkg for constants, command codes and the month table.
module ttc_dpath
   import ttc_pkg::*;
(
   input  logic        clock,
   input  ttc_cmd_type cmd,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_stamp,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millis
);

   // Working registers.
   logic [1:0]  func_ff;
   logic [31:0] secs_ff;
   logic [15:0] ms_low_ff;
   logic [63:0] mprod_ff;
   logic [63:0] prod_ff;
   logic [15:0] ms16_ff;
   logic [32:0] msprod_ff;
   logic [26:0] mins_ff;
   logic [5:0]  second_ff;
   logic [9:0]  millis_ff;
   logic [20:0] hours_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  quad_ff;
   logic [15:0] hq_ff;
   logic [11:0] year_ff;
   logic [13:0] thy_ff;
   logic [4:0]  hour_ff;
   logic [8:0]  doy_ff;

   // Result registers.
   logic [11:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;
   logic [9:0]  rsp_millis_ff;

   // Combinational values.
   logic [31:0] secs_in;
   logic [63:0] mprod_in;
   logic [31:0] stamp_lo;
   logic [31:0] stamp_hi;
   logic [15:0] ms16_in;
   logic [26:0] min_q;
   logic [31:0] sec_rem;
   logic [6:0]  ms_q;
   logic [15:0] ms_rem;
   logic [20:0] hour_q;
   logic [26:0] min_rem;
   logic [5:0]  quad_q;
   logic [20:0] quad_rem;
   logic [15:0] year_hours;
   logic [1:0]  year_add;
   logic [13:0] thy_in;
   logic [11:0] year_in;
   logic [8:0]  day_q;
   logic [13:0] day_rem;
   logic        leap;
   logic        feb29;
   logic [8:0]  doy_adj;
   logic [3:0]  month_idx;
   logic [8:0]  day_calc;

   assign stamp_lo = req_stamp[31:0];
   assign stamp_hi = req_stamp[63:32];

   // Seconds since 1980 and the millisecond product for the selected format.
   always_comb begin
      unique case (req_func)
         FMT_STRUCT: begin
            secs_in  = req_stamp[47:16];
            mprod_in = 64'd0;
         end
         FMT_IEC: begin
            secs_in  = stamp_hi - EPOCH_SHIFT;
            mprod_in = 64'(stamp_lo) * 64'(MS_PER_SEC);
         end
         FMT_MICRO: begin
            secs_in  = stamp_hi - EPOCH_SHIFT;
            mprod_in = 64'(stamp_lo) * RECIP_US;
         end
         default: begin
            secs_in  = stamp_lo - EPOCH_SHIFT;
            mprod_in = 64'd0;
         end
      endcase
   end

   // Sixteen-bit millisecond value.
   always_comb begin
      case (func_ff)
         FMT_STRUCT: ms16_in = ms_low_ff;
         FMT_IEC:    ms16_in = mprod_ff[32 +: 16];
         FMT_MICRO:  ms16_in = mprod_ff[SHIFT_US +: 16];
         default:    ms16_in = 16'd0;
      endcase
   end

   // Quotients and remainders of the constant divisions.
   assign min_q    = prod_ff[SHIFT_60 +: 27];
   assign sec_rem  = secs_ff - (32'(min_q) * 32'd60);
   assign ms_q     = msprod_ff[SHIFT_MS +: 7];
   assign ms_rem   = ms16_ff - (16'(ms_q) * 16'(MS_PER_SEC));
   assign hour_q   = prod_ff[SHIFT_60 +: 21];
   assign min_rem  = mins_ff - (27'(hour_q) * 27'd60);
   assign quad_q   = prod_ff[SHIFT_QUAD +: 6];
   assign quad_rem = hours_ff - (21'(quad_q) * 21'(HOURS_PER_QUAD));
   assign day_q    = prod_ff[SHIFT_DAY +: 9];
   assign day_rem  = thy_ff - (14'(day_q) * 14'd24);

   // Split the hours of a four-year cycle into year offset and hour of year.
   always_comb begin
      year_hours = hq_ff - 16'(HOURS_LEAP_YEAR);
      if (hq_ff < 16'(HOURS_LEAP_YEAR)) begin
         year_add = 2'd0;
         thy_in   = hq_ff[13:0];
      end else if (year_hours >= 16'(2 * HOURS_PLAIN)) begin
         year_add = 2'd3;
         thy_in   = 14'(year_hours - 16'(2 * HOURS_PLAIN));
      end else if (year_hours >= 16'(HOURS_PLAIN)) begin
         year_add = 2'd2;
         thy_in   = 14'(year_hours - 16'(HOURS_PLAIN));
      end else begin
         year_add = 2'd1;
         thy_in   = year_hours[13:0];
      end
      year_in = BASE_YEAR + {4'd0, quad_ff, 2'b00} + 12'(year_add);
   end

   // Month and day from day of year; February 29 is taken out first in a leap year.
   always_comb begin
      leap      = (year_ff[1:0] == 2'b00);
      feb29     = leap && (doy_ff == 9'd60);
      doy_adj   = doy_ff - 9'(leap && (doy_ff > 9'd60));
      month_idx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy_adj > cum_days(4'(k))) begin
            month_idx = 4'(k);
         end
      end
      day_calc  = doy_adj - cum_days(month_idx);
   end

   // One step of work per command.
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            func_ff   <= req_func;
            secs_ff   <= secs_in;
            ms_low_ff <= req_stamp[15:0];
            mprod_ff  <= mprod_in;
         end
         CMD_MUL_SEC: begin
            prod_ff <= 64'(secs_ff) * RECIP_60;
            ms16_ff <= ms16_in;
         end
         CMD_DIV_SEC: begin
            mins_ff   <= min_q;
            second_ff <= sec_rem[5:0];
            msprod_ff <= 33'(ms16_ff) * 33'(RECIP_MS);
         end
         CMD_MUL_MIN: begin
            prod_ff   <= 64'(mins_ff) * RECIP_60;
            millis_ff <= ms_rem[9:0];
         end
         CMD_DIV_MIN: begin
            hours_ff  <= hour_q;
            minute_ff <= min_rem[5:0];
         end
         CMD_MUL_QUAD: begin
            prod_ff <= 64'(hours_ff) * RECIP_QUAD;
         end
         CMD_DIV_QUAD: begin
            quad_ff <= quad_q;
            hq_ff   <= quad_rem[15:0];
         end
         CMD_YEAR: begin
            year_ff <= year_in;
            thy_ff  <= thy_in;
         end
         CMD_MUL_DAY: begin
            prod_ff <= 64'(thy_ff) * RECIP_DAY;
         end
         CMD_DIV_DAY: begin
            hour_ff <= day_rem[4:0];
            doy_ff  <= day_q + 9'd1;
         end
         CMD_RESULT: begin
            rsp_year_ff   <= year_ff;
            rsp_month_ff  <= feb29 ? 4'd2 : month_idx + 4'd1;
            rsp_day_ff    <= feb29 ? 5'd29 : day_calc[4:0];
            rsp_hour_ff   <= hour_ff;
            rsp_minute_ff <= minute_ff;
            rsp_second_ff <= second_ff;
            rsp_millis_ff <= millis_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_hour_ff;
   assign rsp_minute = rsp_minute_ff;
   assign rsp_second = rsp_second_ff;
   assign rsp_millis = rsp_millis_ff;

endmodule

// ----- hdl/timestamp_to_calendar.sv -----
// Top level of the timestamp-to-calendar converter: controller plus datapath.
// Depends on ttc_pkg, ttc_ctrl and ttc_dpath.
//
// Usage:
//   The request channel (req_valid, req_stall, req_func, req_stamp) carries one
//   64-bit timestamp and its format code per transaction. The response channel
//   (rsp_valid, rsp_stall, rsp_year .. rsp_millis) returns one calendar result
//   per request, in order.
//   Each request runs through eleven sequential steps of one shared datapath:
//   format decode, then pairs of reciprocal multiply and remainder steps for
//   minutes, hours, four-year cycles and days, a year split and a month lookup.
//   The result becomes valid as the controller leaves its last step for idle,
//   where it takes the next request; a new request is not taken before the
//   last one is through. req_stall is high while a request is being worked on.
//   The finished result sits in an output register, so the next request is
//   taken while it waits; if rsp_stall holds that register full when the next
//   result is ready, the controller waits in its last step until it drains.
//   A synchronous, active-high reset empties the controller and drops rsp_valid;
//   there is no other state to clear.
module timestamp_to_calendar
   import ttc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millis
);

   ttc_cmd_type cmd;

   // Step sequencer and handshakes.
   ttc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic and result registers.
   ttc_dpath u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .req_func   (req_func),
      .req_stamp  (req_stamp),
      .rsp_year   (rsp_year),
      .rsp_month  (rsp_month),
      .rsp_day    (rsp_day),
      .rsp_hour   (rsp_hour),
      .rsp_minute (rsp_minute),
      .rsp_second (rsp_second),
      .rsp_millis (rsp_millis)
   );

endmodule

// ----- tb/sv/timestamp_to_calendar_checker.sv -----
// Scoreboard for the timestamp-to-calendar block: it watches both channels, predicts each
// calendar result from the accepted request transaction and compares it in order.
// Depends on ttc_pkg for the format codes.
`timescale 1ns / 1ps

module timestamp_to_calendar_checker
   import ttc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_stamp,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   input  logic [9:0]  rsp_millis,
   output int          date_errors,
   output int          dates_open,
   output int          dates_checked
);

   // Seconds from 1970-01-01 to 1980-01-01, and hour counts of the calendar cycles.
   localparam logic [31:0] SECS_1970_TO_1980 = 32'd315532800;
   localparam int unsigned QUAD_HOURS        = 1461 * 24;
   localparam int unsigned LEAP_YEAR_HOURS   = 366 * 24;
   localparam int unsigned PLAIN_YEAR_HOURS  = 365 * 24;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millis;
   } calendar_type;

   calendar_type pending_dates[$];

   // Calendar date of one timestamp; every fourth year from 1980 is taken as leap.
   function automatic calendar_type to_calendar(input logic [1:0] fmt,
                                                input logic [63:0] stamp);
      calendar_type cal;
      logic [31:0]  secs;
      logic [31:0]  ms;
      logic [31:0]  t;
      logic [31:0]  rem;
      logic [31:0]  year;
      logic [31:0]  month;
      logic [31:0]  mlen;
      logic [63:0]  frac_ms;
      logic         scanning;

      // Reduce each format to seconds since 1980 and a 16-bit millisecond value.
      case (fmt)
         FMT_STRUCT: begin
            secs = stamp[47:16];
            ms   = {16'd0, stamp[15:0]};
         end
         FMT_IEC: begin
            secs    = stamp[63:32] - SECS_1970_TO_1980;
            frac_ms = {32'd0, stamp[31:0]} * 64'd1000;
            ms      = {16'd0, frac_ms[47:32]};
         end
         FMT_MICRO: begin
            secs = stamp[63:32] - SECS_1970_TO_1980;
            ms   = (stamp[31:0] / 32'd1000) & 32'h0000_FFFF;
         end
         default: begin
            secs = stamp[31:0] - SECS_1970_TO_1980;
            ms   = 32'd0;
         end
      endcase

      // Seconds and minutes, then split the hours into four-year cycles and years.
      t          = secs;
      rem        = t % 32'd60;
      cal.second = rem[5:0];
      t          = t / 32'd60;
      rem        = t % 32'd60;
      cal.minute = rem[5:0];
      t          = t / 32'd60;

      year = 32'd1980 + ((t / QUAD_HOURS) << 2);
      t    = t % QUAD_HOURS;
      if (t >= LEAP_YEAR_HOURS) begin
         t    = t - LEAP_YEAR_HOURS;
         year = year + 32'd1 + t / PLAIN_YEAR_HOURS;
         t    = t % PLAIN_YEAR_HOURS;
      end

      rem      = t % 32'd24;
      cal.hour = rem[4:0];
      t        = t / 32'd24 + 32'd1;

      // Day of year to month and day; the leap day is taken out before the month scan.
      if (year[1:0] == 2'd0 && t == 32'd60) begin
         month = 32'd2;
      end else begin
         if (year[1:0] == 2'd0 && t > 32'd60) begin
            t = t - 32'd1;
         end
         month    = 32'd0;
         scanning = 1'b1;
         while (scanning) begin
            case (month)
               32'd1:                      mlen = 32'd28;
               32'd3, 32'd5, 32'd8, 32'd10: mlen = 32'd30;
               default:                    mlen = 32'd31;
            endcase
            if (month < 32'd11 && mlen < t) begin
               t     = t - mlen;
               month = month + 32'd1;
            end else begin
               scanning = 1'b0;
            end
         end
         month = month + 32'd1;
      end
      if (year[1:0] == 2'd0 && month == 32'd2 && t == 32'd60) begin
         t = 32'd29;
      end

      cal.year  = year[11:0];
      cal.month = month[3:0];
      cal.day   = t[4:0];
      rem       = ms % 32'd1000;
      cal.millis = rem[9:0];
      return cal;
   endfunction

   // Compare each result transaction with the oldest prediction, then queue new ones.
   always @(posedge clock) begin : watch
      calendar_type got;
      calendar_type want;
      if (reset) begin
         pending_dates.delete();
         dates_open = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second, rsp_millis};
            if (pending_dates.size() == 0) begin
               date_errors = date_errors + 1;
               if (date_errors <= 10) begin
                  $display("%0t: result with nothing outstanding: %0d-%0d-%0d %0d:%0d:%0d.%0d",
                           $realtime, got.year, got.month, got.day, got.hour, got.minute,
                           got.second, got.millis);
               end
            end else begin
               want          = pending_dates.pop_front();
               dates_checked = dates_checked + 1;
               if (got !== want) begin
                  date_errors = date_errors + 1;
                  if (date_errors <= 10) begin
                     $display("%0t: mismatch, expected %0d-%0d-%0d %0d:%0d:%0d.%0d",
                              $realtime, want.year, want.month, want.day, want.hour,
                              want.minute, want.second, want.millis);
                     $display("   got %0d-%0d-%0d %0d:%0d:%0d.%0d",
                              got.year, got.month, got.day, got.hour, got.minute,
                              got.second, got.millis);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_dates.push_back(to_calendar(req_func, req_stamp));
         end
         dates_open = pending_dates.size();
      end
   end

endmodule

// ----- tb/sv/timestamp_to_calendar_tb.sv -----
// Top of the timestamp-to-calendar testbench: clock, reset, request stimulus and result stalls.
// Depends on ttc_pkg, the timestamp_to_calendar block and timestamp_to_calendar_checker.
`timescale 1ns / 1ps

module timestamp_to_calendar_tb;
   import ttc_pkg::*;

   localparam int unsigned SECS_PER_DAY = 86400;
   localparam logic [31:0] UNIX_1980    = 32'd315532800;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [63:0] req_stamp;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [9:0]  rsp_millis;

   int date_errors;
   int dates_open;
   int dates_checked;
   int hold_left = 0;
   bit idling = 1'b0;
   int stamps_sent = 0;
   int stamps_per_format[4];

   timestamp_to_calendar uut (.*);

   timestamp_to_calendar_checker checker_i (.*);

   always #2 clock = ~clock;

   // Result side: a long hold when asked for, otherwise random stall bursts while idling is set.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Builds a stamp of the given format that stands for the given seconds since 1980.
   function automatic logic [63:0] encode_stamp(input logic [1:0] fmt, input logic [31:0] secs);
      logic [31:0] since_1970;
      logic [31:0] noise;
      logic [31:0] ms;
      logic [63:0] stamp;
      since_1970 = secs + UNIX_1980;
      noise      = $urandom;
      ms         = $urandom_range(0, 999);
      case (fmt)
         FMT_STRUCT:  stamp = {noise[15:0], secs, ms[15:0]};
         FMT_IEC:     stamp = {since_1970, noise};
         FMT_MICRO:   stamp = {since_1970, 32'($urandom_range(0, 999999))};
         default:     stamp = {noise, since_1970};
      endcase
      return stamp;
   endfunction

   // Seconds since 1980, mostly close to a day, month or year boundary of some four-year cycle.
   function automatic logic [31:0] boundary_secs();
      logic [31:0] day;
      logic [31:0] offset;
      case ($urandom_range(0, 15))
         0:       day = 32'd0;
         1:       day = 32'd30;
         2:       day = 32'd31;
         3:       day = 32'd58;
         4:       day = 32'd59;
         5:       day = 32'd60;
         6:       day = 32'd365;
         7:       day = 32'd366;
         8:       day = 32'd424;
         9:       day = 32'd425;
         10:      day = 32'd730;
         11:      day = 32'd731;
         12:      day = 32'd1095;
         13:      day = 32'd1096;
         14:      day = 32'd1460;
         default: day = $urandom_range(0, 1460);
      endcase
      day = day + 32'd1461 * $urandom_range(0, 33);
      case ($urandom_range(0, 4))
         0:       offset = 32'd0;
         1:       offset = 32'd1;
         2:       offset = SECS_PER_DAY - 32'd1;
         3:       offset = 32'd3600 * $urandom_range(0, 23) + 32'd59 * $urandom_range(0, 1);
         default: offset = $urandom_range(0, SECS_PER_DAY - 1);
      endcase
      return day * SECS_PER_DAY + offset;
   endfunction

   // Offers one request transaction, after an optional gap, and returns once it is taken.
   task automatic send_stamp(input logic [1:0] fmt, input logic [63:0] stamp);
      if (idling && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_func  <= 2'($urandom);
         req_stamp <= {$urandom, $urandom};
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= fmt;
      req_stamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stamps_sent = stamps_sent + 1;
      stamps_per_format[fmt] = stamps_per_format[fmt] + 1;
   endtask

   // One random request: raw noise, plausible stamps, or stamps near calendar boundaries.
   task automatic send_random_stamp();
      logic [1:0]  fmt;
      logic [63:0] stamp;
      fmt = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0, 1, 2:    stamp = {$urandom, $urandom};
         3, 4, 5, 6: stamp = encode_stamp(fmt, $urandom);
         default:    stamp = encode_stamp(fmt, boundary_secs());
      endcase
      send_stamp(fmt, stamp);
   endtask

   // Drops req_valid and waits until all outstanding results are back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (dates_open == 0);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FMT_STRUCT;
      req_stamp = 64'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed stamps: field extremes, each format, dates before 1980, large
      // millisecond values, leap days and year ends.
      send_stamp(FMT_STRUCT, 64'd0);
      send_stamp(FMT_STRUCT, ALL_ONES);
      send_stamp(FMT_IEC, 64'd0);
      send_stamp(FMT_IEC, ALL_ONES);
      send_stamp(FMT_MICRO, 64'd0);
      send_stamp(FMT_MICRO, ALL_ONES);
      send_stamp(FMT_SECONDS, ALL_ONES);
      send_stamp(FMT_SECONDS, {32'hFFFF_FFFF, UNIX_1980});
      send_stamp(FMT_SECONDS, {32'd0, UNIX_1980 - 32'd1});
      send_stamp(FMT_STRUCT, {16'd0, 32'd5097600, 16'd999});
      send_stamp(FMT_STRUCT, {16'd0, 32'd5097599, 16'd1000});
      send_stamp(FMT_STRUCT, {16'd0, 32'd5184000, 16'd0});
      send_stamp(FMT_STRUCT, {16'hFFFF, 32'd31622399, 16'd65535});
      send_stamp(FMT_STRUCT, {16'd0, 32'd31622400, 16'd1});
      send_stamp(FMT_STRUCT, {16'd0, 32'd36719999, 16'd0});
      send_stamp(FMT_STRUCT, {16'd0, 32'd36720000, 16'd0});
      send_stamp(FMT_STRUCT, {16'd0, 32'd3792009600, 16'd500});
      send_stamp(FMT_MICRO, {UNIX_1980 + 32'd86399, 32'd999999});
      send_stamp(FMT_MICRO, {32'd1700000000, 32'd65536000});
      send_stamp(FMT_IEC, {32'd1700000000, 32'h8000_0000});
      send_stamp(FMT_SECONDS, {32'd0, 32'd1709164800});
      drain();

      // Random traffic with gaps and stalls on both sides.
      idling = 1'b1;
      for (int n = 0; n < 1000; n++) begin
         if (n == 300) begin
            // Long result stall while requests keep coming, so the block backs up.
            hold_left = 400;
         end
         if (n == 600) begin
            drain();
         end
         send_random_stamp();
      end

      // Full-rate tail with no idling on either side.
      idling = 1'b0;
      for (int n = 0; n < 200; n++) begin
         send_random_stamp();
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d timestamps (struct %0d, IEC %0d, microsecond %0d, seconds %0d).",
               stamps_sent, stamps_per_format[0], stamps_per_format[1],
               stamps_per_format[2], stamps_per_format[3]);
      $display("Checked %0d calendar results, %0d mismatches, incl. a long result stall.",
               dates_checked, date_errors);
      if (date_errors == 0 && dates_open == 0) begin
         $display("timestamp_to_calendar_tb OK");
      end else begin
         $display("timestamp_to_calendar_tb NOT OK");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", dates_open);
      $display("timestamp_to_calendar_tb NOT OK");
      $finish;
   end

endmodule
